// ----- rtl/mpd_pkg.sv -----
// ----------------------------------------------------------------------------
// mpd_pkg: shared types and constants of the MQTT packet deframer
// Phase and result codes, the item passed from the header decoder to the
// result sequencer, and the sizes of the length field and the item queue.
// ----------------------------------------------------------------------------
package mpd_pkg;

	localparam int MAX_LENGTH_GROUPS_DEF = 3;
	localparam int LEN_W                 = 21;
	localparam int QUEUE_DEPTH           = 4;

	localparam logic [3:0] PT_CONNACK  = 4'd2;
	localparam logic [3:0] PT_PUBLISH  = 4'd3;
	localparam logic [3:0] PT_PINGRESP = 4'd13;

	localparam logic [7:0] PUBACK_HDR = 8'h40;
	localparam logic [7:0] PUBACK_LEN = 8'h02;

	localparam logic [1:0] QOS_NONE = 2'd0;
	localparam logic [1:0] QOS_ONE  = 2'd1;

	typedef enum logic [3:0] {
		PH_HEADER  = 4'd0,
		PH_LENGTH  = 4'd1,
		PH_SKIP    = 4'd2,
		PH_DROP    = 4'd3,
		PH_TLEN_HI = 4'd4,
		PH_TLEN_LO = 4'd5,
		PH_TOPIC   = 4'd6,
		PH_PID_HI  = 4'd7,
		PH_PID_LO  = 4'd8,
		PH_BODY    = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		K_CONNACK  = 3'd0,
		K_TOPIC    = 3'd1,
		K_BODY     = 3'd2,
		K_PUB_END  = 3'd3,
		K_ACK      = 3'd4,
		K_OTHER    = 3'd5,
		K_LEN_ERR  = 3'd6,
		K_PUB_DROP = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		ST_ACK0  = 3'd0,
		ST_ACK1  = 3'd1,
		ST_ACK2  = 3'd2,
		ST_ACK3  = 3'd3,
		ST_TOPIC = 3'd4,
		ST_MAIN  = 3'd5
	} step_t;

	typedef struct packed {
		logic             ack;
		logic             topic;
		logic             body;
		logic             main;
		kind_t            mkind;
		logic [7:0]       data;
		logic [3:0]       ptype;
		logic [1:0]       qos;
		logic [15:0]      pid;
		logic [15:0]      tlen;
		logic [LEN_W-1:0] blen;
	} desc_t;

endpackage

// ----- rtl/mpd_front.sv -----
// ----------------------------------------------------------------------------
// mpd_front: fixed header decoder
// Takes one received byte per cycle while accept is high, tracks the packet
// phase and hands one item per byte that causes results to the item queue.
// ----------------------------------------------------------------------------
module mpd_front #(
	parameter int MAX_LENGTH_GROUPS = mpd_pkg::MAX_LENGTH_GROUPS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     rx_byte,
	output logic           desc_valid,
	output mpd_pkg::desc_t desc
);

	localparam int LW = mpd_pkg::LEN_W;
	localparam int GW = $clog2(MAX_LENGTH_GROUPS + 1);
	localparam int SW = LW + 8;

	mpd_pkg::phase_t phase_q, phase_d;
	logic [7:0]      hdr_q, hdr_d;
	logic [LW-1:0]   len_q, len_d;
	logic [GW-1:0]   grp_q, grp_d;
	logic [LW-1:0]   bl_q, bl_d;
	logic [15:0]     tlen_q, tlen_d;
	logic [15:0]     tleft_q, tleft_d;
	logic [15:0]     pid_q, pid_d;
	logic            ack_q, ack_d;

	logic            tb;
	logic            bb;
	logic            mv;
	mpd_pkg::kind_t  mkind;

	logic [LW-1:0]   dec;
	logic [4:0]      shamt;
	logic [SW-1:0]   sum;
	logic [LW-1:0]   len_acc;
	logic            is_pub;
	logic [1:0]      qos;
	logic            other_mv;
	mpd_pkg::kind_t  other_kind;
	logic [15:0]     tlen_n;
	logic [16:0]     need;
	logic [15:0]     tleft_n;

	assign dec     = bl_q - LW'(bl_q != '0);
	assign shamt   = 5'(grp_q) * 5'd7;
	assign sum     = {8'b0, len_q} + ({(SW - 7)'(0), rx_byte[6:0]} << shamt);
	assign len_acc = (|sum[SW-1:LW]) ? {LW{1'b1}} : sum[LW-1:0];
	assign is_pub  = (hdr_q[7:4] == mpd_pkg::PT_PUBLISH);
	assign qos     = is_pub ? hdr_q[2:1] : mpd_pkg::QOS_NONE;
	assign other_mv   = (hdr_q[7:4] != mpd_pkg::PT_PINGRESP);
	assign other_kind = (hdr_q[7:4] == mpd_pkg::PT_CONNACK) ? mpd_pkg::K_CONNACK
		: mpd_pkg::K_OTHER;
	assign tlen_n  = {tleft_q[7:0], rx_byte};
	assign need    = {1'b0, tlen_n} + ((qos != mpd_pkg::QOS_NONE) ? 17'd2 : 17'd0);
	assign tleft_n = tleft_q - 16'(tleft_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mpd_pkg::PH_HEADER;
			hdr_q   <= '0;
			len_q   <= '0;
			grp_q   <= '0;
			bl_q    <= '0;
			tlen_q  <= '0;
			tleft_q <= '0;
			pid_q   <= '0;
			ack_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			hdr_q   <= hdr_d;
			len_q   <= len_d;
			grp_q   <= grp_d;
			bl_q    <= bl_d;
			tlen_q  <= tlen_d;
			tleft_q <= tleft_d;
			pid_q   <= pid_d;
			ack_q   <= ack_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		hdr_d   = hdr_q;
		len_d   = len_q;
		grp_d   = grp_q;
		bl_d    = bl_q;
		tlen_d  = tlen_q;
		tleft_d = tleft_q;
		pid_d   = pid_q;
		ack_d   = ack_q;
		tb      = 1'b0;
		bb      = 1'b0;
		mv      = 1'b0;
		mkind   = mpd_pkg::K_OTHER;
		if (accept) begin
			ack_d = 1'b0;
			unique case (phase_q)
				mpd_pkg::PH_HEADER: begin
					hdr_d   = rx_byte;
					len_d   = '0;
					grp_d   = '0;
					bl_d    = '0;
					tlen_d  = '0;
					tleft_d = '0;
					pid_d   = '0;
					phase_d = mpd_pkg::PH_LENGTH;
				end
				mpd_pkg::PH_LENGTH: begin
					if (grp_q >= GW'(MAX_LENGTH_GROUPS)) begin
						mv      = 1'b1;
						mkind   = mpd_pkg::K_LEN_ERR;
						phase_d = mpd_pkg::PH_HEADER;
					end else begin
						len_d = len_acc;
						grp_d = grp_q + GW'(1);
						if (!rx_byte[7]) begin
							bl_d = len_acc;
							if (is_pub) begin
								if (len_acc < LW'(2)) begin
									if (len_acc == '0) begin
										mv      = 1'b1;
										mkind   = mpd_pkg::K_PUB_DROP;
										phase_d = mpd_pkg::PH_HEADER;
									end else begin
										phase_d = mpd_pkg::PH_DROP;
									end
								end else begin
									phase_d = mpd_pkg::PH_TLEN_HI;
								end
							end else if (len_acc == '0) begin
								mv      = other_mv;
								mkind   = other_kind;
								phase_d = mpd_pkg::PH_HEADER;
							end else begin
								phase_d = mpd_pkg::PH_SKIP;
							end
						end
					end
				end
				mpd_pkg::PH_SKIP: begin
					bl_d = dec;
					if (dec == '0) begin
						mv      = other_mv;
						mkind   = other_kind;
						phase_d = mpd_pkg::PH_HEADER;
					end
				end
				mpd_pkg::PH_DROP: begin
					bl_d = dec;
					if (dec == '0) begin
						mv      = 1'b1;
						mkind   = mpd_pkg::K_PUB_DROP;
						phase_d = mpd_pkg::PH_HEADER;
					end
				end
				mpd_pkg::PH_TLEN_HI: begin
					tleft_d = {8'b0, rx_byte};
					bl_d    = dec;
					phase_d = mpd_pkg::PH_TLEN_LO;
				end
				mpd_pkg::PH_TLEN_LO: begin
					tlen_d  = tlen_n;
					tleft_d = tlen_n;
					bl_d    = dec;
					if (dec < {4'b0, need}) begin
						if (dec == '0) begin
							mv      = 1'b1;
							mkind   = mpd_pkg::K_PUB_DROP;
							phase_d = mpd_pkg::PH_HEADER;
						end else begin
							phase_d = mpd_pkg::PH_DROP;
						end
					end else if (tlen_n != '0) begin
						phase_d = mpd_pkg::PH_TOPIC;
					end else if (qos != mpd_pkg::QOS_NONE) begin
						phase_d = mpd_pkg::PH_PID_HI;
					end else if (dec == '0) begin
						mv      = 1'b1;
						mkind   = mpd_pkg::K_PUB_END;
						phase_d = mpd_pkg::PH_HEADER;
					end else begin
						phase_d = mpd_pkg::PH_BODY;
					end
				end
				mpd_pkg::PH_TOPIC: begin
					tb      = 1'b1;
					tleft_d = tleft_n;
					bl_d    = dec;
					if (tleft_n == '0) begin
						if (qos != mpd_pkg::QOS_NONE) begin
							phase_d = mpd_pkg::PH_PID_HI;
						end else if (dec == '0) begin
							mv      = 1'b1;
							mkind   = mpd_pkg::K_PUB_END;
							phase_d = mpd_pkg::PH_HEADER;
						end else begin
							phase_d = mpd_pkg::PH_BODY;
						end
					end
				end
				mpd_pkg::PH_PID_HI: begin
					pid_d   = {rx_byte, 8'b0};
					bl_d    = dec;
					phase_d = mpd_pkg::PH_PID_LO;
				end
				mpd_pkg::PH_PID_LO: begin
					pid_d = {pid_q[15:8], rx_byte};
					bl_d  = dec;
					if (dec == '0) begin
						mv      = 1'b1;
						mkind   = mpd_pkg::K_PUB_END;
						ack_d   = (qos == mpd_pkg::QOS_ONE);
						phase_d = mpd_pkg::PH_HEADER;
					end else begin
						phase_d = mpd_pkg::PH_BODY;
					end
				end
				mpd_pkg::PH_BODY: begin
					mv    = 1'b1;
					mkind = mpd_pkg::K_BODY;
					bl_d  = dec;
					if (dec == '0) begin
						tb      = 1'b1;
						bb      = 1'b1;
						mkind   = mpd_pkg::K_PUB_END;
						ack_d   = (qos == mpd_pkg::QOS_ONE);
						phase_d = mpd_pkg::PH_HEADER;
					end
				end
				default: begin
					phase_d = mpd_pkg::PH_HEADER;
				end
			endcase
		end
	end

	logic [1:0] qos_d;
	assign qos_d = (hdr_d[7:4] == mpd_pkg::PT_PUBLISH) ? hdr_d[2:1] : mpd_pkg::QOS_NONE;

	assign desc_valid = accept && (ack_q || tb || mv);

	always_comb begin
		desc.ack   = ack_q;
		desc.topic = tb;
		desc.body  = bb;
		desc.main  = mv;
		desc.mkind = mkind;
		desc.data  = rx_byte;
		desc.ptype = hdr_d[7:4];
		desc.qos   = qos_d;
		desc.pid   = pid_d;
		desc.tlen  = tlen_d;
		desc.blen  = (mkind == mpd_pkg::K_LEN_ERR) ? '0 : len_d;
	end

endmodule

// ----- rtl/mpd_queue.sv -----
// ----------------------------------------------------------------------------
// mpd_queue: item queue between header decoder and result sequencer
// A few entries deep so that each side can stall on its own.
// ----------------------------------------------------------------------------
module mpd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mpd_pkg::desc_t din,
	output logic           full,
	input  logic           pop,
	output mpd_pkg::desc_t dout,
	output logic           empty
);

	localparam int D  = mpd_pkg::QUEUE_DEPTH;
	localparam int PW = (D > 1) ? $clog2(D) : 1;
	localparam int CW = $clog2(D + 1);

	mpd_pkg::desc_t mem_q [D];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == CW'(D));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(D - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(D - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

// ----- rtl/mpd_back.sv -----
// ----------------------------------------------------------------------------
// mpd_back: result sequencer
// Expands each queued item into its results: the four PUBACK bytes when an
// acknowledgement is due, then the topic or body byte and the main result.
// ----------------------------------------------------------------------------
module mpd_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	input  mpd_pkg::desc_t            q_head,
	output logic                      q_pop,
	output logic                      empty,
	input  logic                      pop,
	output logic [2:0]                kind,
	output logic [7:0]                data_byte,
	output logic [3:0]                packet_type,
	output logic [1:0]                qos_level,
	output logic [15:0]               message_id,
	output logic [15:0]               topic_size,
	output logic [mpd_pkg::LEN_W-1:0] body_size,
	output logic                      last
);

	mpd_pkg::desc_t   cur_q;
	logic             valid_q;
	mpd_pkg::step_t   step_q;
	mpd_pkg::step_t   nxt;
	mpd_pkg::step_t   first;
	logic             has_next;
	logic             advance;
	logic             load;

	logic [3:0]                ack_ptype_q;
	logic [1:0]                ack_qos_q;
	logic [15:0]               ack_pid_q;
	logic [15:0]               ack_tlen_q;
	logic [mpd_pkg::LEN_W-1:0] ack_blen_q;

	assign advance = valid_q && pop;
	assign load    = !q_empty && (!valid_q || (advance && !has_next));
	assign q_pop   = load;
	assign empty   = !valid_q;

	always_comb begin
		if (q_head.ack) begin
			first = mpd_pkg::ST_ACK0;
		end else if (q_head.topic) begin
			first = mpd_pkg::ST_TOPIC;
		end else begin
			first = mpd_pkg::ST_MAIN;
		end
	end

	always_comb begin
		nxt      = mpd_pkg::ST_MAIN;
		has_next = 1'b0;
		unique case (step_q)
			mpd_pkg::ST_ACK0: begin
				nxt      = mpd_pkg::ST_ACK1;
				has_next = 1'b1;
			end
			mpd_pkg::ST_ACK1: begin
				nxt      = mpd_pkg::ST_ACK2;
				has_next = 1'b1;
			end
			mpd_pkg::ST_ACK2: begin
				nxt      = mpd_pkg::ST_ACK3;
				has_next = 1'b1;
			end
			mpd_pkg::ST_ACK3: begin
				nxt      = cur_q.topic ? mpd_pkg::ST_TOPIC : mpd_pkg::ST_MAIN;
				has_next = cur_q.topic || cur_q.main;
			end
			mpd_pkg::ST_TOPIC: begin
				nxt      = mpd_pkg::ST_MAIN;
				has_next = cur_q.main;
			end
			default: begin
				nxt      = mpd_pkg::ST_MAIN;
				has_next = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= mpd_pkg::ST_MAIN;
		end else if (load) begin
			valid_q <= 1'b1;
			step_q  <= first;
		end else if (advance) begin
			if (has_next) begin
				step_q <= nxt;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_head;
		end
		if (advance && step_q == mpd_pkg::ST_MAIN && cur_q.mkind == mpd_pkg::K_PUB_END) begin
			ack_ptype_q <= cur_q.ptype;
			ack_qos_q   <= cur_q.qos;
			ack_pid_q   <= cur_q.pid;
			ack_tlen_q  <= cur_q.tlen;
			ack_blen_q  <= cur_q.blen;
		end
	end

	always_comb begin
		kind        = cur_q.mkind;
		data_byte   = (cur_q.mkind == mpd_pkg::K_BODY) ? cur_q.data : 8'h00;
		packet_type = cur_q.ptype;
		qos_level   = cur_q.qos;
		message_id  = cur_q.pid;
		topic_size  = cur_q.tlen;
		body_size   = cur_q.blen;
		last        = 1'b1;
		unique case (step_q)
			mpd_pkg::ST_ACK0, mpd_pkg::ST_ACK1, mpd_pkg::ST_ACK2, mpd_pkg::ST_ACK3: begin
				kind        = mpd_pkg::K_ACK;
				packet_type = ack_ptype_q;
				qos_level   = ack_qos_q;
				message_id  = ack_pid_q;
				topic_size  = ack_tlen_q;
				body_size   = ack_blen_q;
				last        = (step_q == mpd_pkg::ST_ACK3) && !cur_q.topic && !cur_q.main;
				case (step_q)
					mpd_pkg::ST_ACK0: data_byte = mpd_pkg::PUBACK_HDR;
					mpd_pkg::ST_ACK1: data_byte = mpd_pkg::PUBACK_LEN;
					mpd_pkg::ST_ACK2: data_byte = ack_pid_q[15:8];
					default:          data_byte = ack_pid_q[7:0];
				endcase
			end
			mpd_pkg::ST_TOPIC: begin
				kind      = cur_q.body ? mpd_pkg::K_BODY : mpd_pkg::K_TOPIC;
				data_byte = cur_q.data;
				last      = !cur_q.main;
			end
			default: begin
				last = 1'b1;
			end
		endcase
	end

endmodule

// ----- rtl/mqtt_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// mqtt_packet_deframer: streaming deframer for received MQTT packets
// Usage:
//   Input side is a queue write port: drive rx_byte and push; a byte is taken
//   at a clock edge with push high and full low. One byte per cycle is taken
//   for as long as full stays low.
//   Result side is a queue read port: while empty is low the oldest result is
//   on kind, data_byte and the packet fields; pop high takes it. last marks
//   the final result caused by one received byte.
//   A taken byte's item goes through the item queue into the result register
//   before its first result shows. Throughput is one byte per cycle while full
//   stays low; a byte that causes several results (a PUBACK burst of four
//   bytes, a topic byte followed by the publish end) takes one pop per result.
//   The header decoder writes into a four-entry item queue; full rises when
//   that queue fills, which happens only when the receiver stops popping or
//   falls behind during PUBACK bursts.
//   Reset clears the decoder to wait for a header byte and empties the queue
//   and the result register.
// ----------------------------------------------------------------------------
module mqtt_packet_deframer #(
	parameter int MAX_LENGTH_GROUPS = mpd_pkg::MAX_LENGTH_GROUPS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [7:0]                rx_byte,
	output logic                      empty,
	input  logic                      pop,
	output logic [2:0]                kind,
	output logic [7:0]                data_byte,
	output logic [3:0]                packet_type,
	output logic [1:0]                qos_level,
	output logic [15:0]               message_id,
	output logic [15:0]               topic_size,
	output logic [mpd_pkg::LEN_W-1:0] body_size,
	output logic                      last
);

	logic           accept;
	logic           desc_valid;
	mpd_pkg::desc_t desc;
	logic           q_empty;
	logic           q_pop;
	mpd_pkg::desc_t q_head;

	assign accept = push && !full;

	mpd_front #(
		.MAX_LENGTH_GROUPS(MAX_LENGTH_GROUPS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.desc_valid(desc_valid),
		.desc      (desc)
	);

	mpd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (desc_valid),
		.din   (desc),
		.full  (full),
		.pop   (q_pop),
		.dout  (q_head),
		.empty (q_empty)
	);

	mpd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.kind       (kind),
		.data_byte  (data_byte),
		.packet_type(packet_type),
		.qos_level  (qos_level),
		.message_id (message_id),
		.topic_size (topic_size),
		.body_size  (body_size),
		.last       (last)
	);

endmodule

// ----- rtl/mpd_checker.sv -----
// ----------------------------------------------------------------------------
// mpd_checker: port-level checks of the MQTT packet deframer
// Watches the result port and the fields it carries.
// ----------------------------------------------------------------------------
module mpd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      push,
	input logic                      full,
	input logic [7:0]                rx_byte,
	input logic                      empty,
	input logic                      pop,
	input logic [2:0]                kind,
	input logic [7:0]                data_byte,
	input logic [3:0]                packet_type,
	input logic [1:0]                qos_level,
	input logic [15:0]               message_id,
	input logic [15:0]               topic_size,
	input logic [mpd_pkg::LEN_W-1:0] body_size,
	input logic                      last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(kind) && $stable(data_byte) && $stable(last))
		else $error("result changed while stalled");

	a_ack_src: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind == mpd_pkg::K_ACK |->
			packet_type == mpd_pkg::PT_PUBLISH && qos_level == mpd_pkg::QOS_ONE)
		else $error("ack byte without QoS-1 publish");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind != mpd_pkg::K_TOPIC && kind != mpd_pkg::K_BODY
			&& kind != mpd_pkg::K_ACK |-> data_byte == 8'h00)
		else $error("data byte set on a status result");

	a_len_err: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind == mpd_pkg::K_LEN_ERR |-> last && body_size == '0)
		else $error("length error result malformed");

	a_qos_pub: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && qos_level != mpd_pkg::QOS_NONE |-> packet_type == mpd_pkg::PT_PUBLISH)
		else $error("qos set on a non-publish result");

endmodule

bind mqtt_packet_deframer mpd_checker u_mpd_checker (.*);
